>>> rtl/crt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crt_pkg
// Shared constants, types and command/status codes for the CRT reconstruction
// unit.
// ----------------------------------------------------------------------------
package crt_pkg;

    localparam int MAX_PARTS   = 4;
    localparam int VALUE_BITS  = 31;
    localparam int NUM_PARTS_W = 3;
    localparam int PART_IDX_W  = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
    localparam int PART_CNT_W  = $clog2(MAX_PARTS + 1);
    localparam int CFG_IDX_W   = $clog2(2 + MAX_PARTS);
    localparam int SW          = VALUE_BITS + 2;
    localparam int CNT_W       = $clog2(VALUE_BITS + 1);

    typedef logic [VALUE_BITS-1:0] word_t;
    typedef logic signed [SW-1:0]  sword_t;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_PARTS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL     = CFG_IDX_W'(1);
    localparam int                   REG_PART_BASE = 2;

    typedef logic [2:0] op_t;
    localparam op_t OP_NOP      = 3'd0;
    localparam op_t OP_CLEAR    = 3'd1;
    localparam op_t OP_EUC_INIT = 3'd2;
    localparam op_t OP_EUC_MUL  = 3'd3;
    localparam op_t OP_EUC_UPD  = 3'd4;
    localparam op_t OP_FIX      = 3'd5;
    localparam op_t OP_ACC      = 3'd6;
    localparam op_t OP_NEXT     = 3'd7;

    typedef logic [2:0] dsel_t;
    localparam dsel_t DS_C    = 3'd0;  // total / part -> cofactor
    localparam dsel_t DS_EUC  = 3'd1;  // r0 / r1
    localparam dsel_t DS_SABS = 3'd2;  // |s0| mod part
    localparam dsel_t DS_INV  = 3'd3;  // inverse mod total
    localparam dsel_t DS_CM   = 3'd4;  // cofactor mod total
    localparam dsel_t DS_XM   = 3'd5;  // residue mod total

    localparam logic MS_INV_C  = 1'b0;
    localparam logic MS_TERM_X = 1'b1;

    typedef struct packed {
        op_t   op;
        logic  div_go;
        dsel_t div_sel;
        logic  mm_go;
        logic  mm_sel;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic part_avail;
        logic part_skip;
        logic r1_zero;
    } stat_t;

endpackage
`default_nettype wire

>>> rtl/residue_to_integer_crt_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// residue_to_integer_crt_unit
// Chinese remainder reconstruction of one integer from per-part residues.
// ----------------------------------------------------------------------------
// One item at a time. Each used part (total and part modulus nonzero) runs an
// extended-Euclid loop (1 to about 46 steps for 31-bit moduli), the reductions
// and two modular products; other parts are skipped. All the work goes through
// one 1-bit-per-cycle divider and one shift-add modular multiplier. The result
// beat is held on m_value until taken; s_ready is high only when idle.
// Write the configuration only while no item is in flight.
module residue_to_integer_crt_unit (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  crt_pkg::word_t                  s_residue_0,
    input  crt_pkg::word_t                  s_residue_1,
    input  crt_pkg::word_t                  s_residue_2,
    input  crt_pkg::word_t                  s_residue_3,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output crt_pkg::word_t                  m_value,
    input  wire logic                       cfg_we,
    input  wire logic [crt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  crt_pkg::word_t                  cfg_data
);
    import crt_pkg::*;

    logic [NUM_PARTS_W-1:0] num_parts_reg;
    word_t                  total_reg;
    word_t                  part_reg [MAX_PARTS];
    word_t                  resid_in [MAX_PARTS];
    cmd_t                   cmd;
    stat_t                  stat;

    assign resid_in[0] = s_residue_0;
    assign resid_in[1] = s_residue_1;
    assign resid_in[2] = s_residue_2;
    assign resid_in[3] = s_residue_3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_parts_reg <= NUM_PARTS_W'(1);
            total_reg     <= VALUE_BITS'(1);
            for (int k = 0; k < MAX_PARTS; k++) begin
                part_reg[k] <= VALUE_BITS'(1);
            end
        end else if (cfg_we) begin
            if (cfg_index == REG_NUM_PARTS) begin
                num_parts_reg <= cfg_data[NUM_PARTS_W-1:0];
            end
            if (cfg_index == REG_TOTAL) begin
                total_reg <= cfg_data;
            end
            for (int k = 0; k < MAX_PARTS; k++) begin
                if (cfg_index == CFG_IDX_W'(REG_PART_BASE + k)) begin
                    part_reg[k] <= cfg_data;
                end
            end
        end
    end

    crt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    crt_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .num_parts (num_parts_reg),
        .total     (total_reg),
        .part_mod  (part_reg),
        .resid_in  (resid_in),
        .stat      (stat),
        .value     (m_value)
    );

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while result pending");

    a_accept_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !m_valid)
        else $error("result beat right after input accept");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> (s_ready && !m_valid))
        else $error("not idle after reset");
`endif

endmodule
`default_nettype wire

>>> rtl/crt_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crt_div
// Restoring unsigned divider, one quotient bit per cycle. Divisor must be
// nonzero.
// ----------------------------------------------------------------------------
module crt_div (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  crt_pkg::word_t     dividend,
    input  crt_pkg::word_t     divisor,
    output logic               done,
    output crt_pkg::word_t     quot,
    output crt_pkg::word_t     rem
);
    import crt_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    word_t            dvd_reg;
    word_t            dvs_reg;
    word_t            rem_reg;
    logic [VALUE_BITS:0] trial;
    logic             ge;
    word_t            rem_next;

    always_comb begin
        trial    = {rem_reg, dvd_reg[VALUE_BITS-1]};
        ge       = trial >= {1'b0, dvs_reg};
        rem_next = ge ? VALUE_BITS'(trial - {1'b0, dvs_reg}) : trial[VALUE_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
            cnt_reg <= CNT_W'(VALUE_BITS);
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[VALUE_BITS-2:0], ge};
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    assign done = done_reg;
    assign quot = dvd_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

>>> rtl/crt_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crt_dp
// CRT datapath: Euclid registers, shared divider, shift-add modular
// multiplier and the result accumulator.
// ----------------------------------------------------------------------------
module crt_dp (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  crt_pkg::cmd_t                  cmd,
    input  wire logic [crt_pkg::NUM_PARTS_W-1:0] num_parts,
    input  crt_pkg::word_t                 total,
    input  crt_pkg::word_t                 part_mod [crt_pkg::MAX_PARTS],
    input  crt_pkg::word_t                 resid_in [crt_pkg::MAX_PARTS],
    output crt_pkg::stat_t                 stat,
    output crt_pkg::word_t                 value
);
    import crt_pkg::*;

    word_t                 resid_reg [MAX_PARTS];
    logic [PART_CNT_W-1:0] i_reg;
    word_t                 res_reg, c_reg, r0_reg, r1_reg, q_reg, rdiv_reg;
    word_t                 srem_reg, inv_reg, cm_reg, xm_reg, term_reg;
    sword_t                s0_reg, s1_reg, prod_reg;
    dsel_t                 dsel_reg;

    logic [PART_IDX_W-1:0]  pidx;
    word_t                  p_cur, x_cur;
    logic [NUM_PARTS_W-1:0] used;
    logic                   s0_neg;
    sword_t                 s0_abs;
    word_t                  div_a, div_b, div_q, div_r;
    logic                   div_done;
    logic [VALUE_BITS:0]    rsum;

    // modular multiplier
    logic             mm_busy_reg, mm_done_reg;
    logic [CNT_W-1:0] mm_cnt_reg;
    word_t            mm_a_reg, mm_b_reg, mm_acc_reg;
    logic [VALUE_BITS:0] mm_sum, mm_dbl;
    word_t            mm_acc_n, mm_a_n;

    assign pidx   = i_reg[PART_IDX_W-1:0];
    assign p_cur  = part_mod[pidx];
    assign x_cur  = resid_reg[pidx];
    assign used   = (num_parts > NUM_PARTS_W'(MAX_PARTS)) ? NUM_PARTS_W'(MAX_PARTS) : num_parts;
    assign s0_neg = s0_reg[SW-1];
    assign s0_abs = s0_neg ? -s0_reg : s0_reg;

    always_comb begin
        case (cmd.div_sel)
            DS_C:    begin div_a = total;                      div_b = p_cur;  end
            DS_EUC:  begin div_a = r0_reg;                     div_b = r1_reg; end
            DS_SABS: begin div_a = s0_abs[VALUE_BITS-1:0];     div_b = p_cur;  end
            DS_INV:  begin div_a = inv_reg;                    div_b = total;  end
            DS_CM:   begin div_a = c_reg;                      div_b = total;  end
            DS_XM:   begin div_a = x_cur;                      div_b = total;  end
            default: begin div_a = r0_reg;                     div_b = r1_reg; end
        endcase
    end

    crt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_go),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    always_comb begin
        mm_sum   = {1'b0, mm_acc_reg} + {1'b0, mm_a_reg};
        mm_acc_n = mm_acc_reg;
        if (mm_b_reg[0]) begin
            mm_acc_n = (mm_sum >= {1'b0, total}) ? VALUE_BITS'(mm_sum - {1'b0, total})
                                                 : mm_sum[VALUE_BITS-1:0];
        end
        mm_dbl = {mm_a_reg, 1'b0};
        mm_a_n = (mm_dbl >= {1'b0, total}) ? VALUE_BITS'(mm_dbl - {1'b0, total})
                                           : mm_dbl[VALUE_BITS-1:0];
        rsum   = {1'b0, res_reg} + {1'b0, term_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mm_busy_reg <= 1'b0;
            mm_done_reg <= 1'b0;
        end else begin
            mm_done_reg <= 1'b0;
            if (cmd.mm_go) begin
                mm_busy_reg <= 1'b1;
            end else if (mm_busy_reg && mm_cnt_reg == CNT_W'(1)) begin
                mm_busy_reg <= 1'b0;
                mm_done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mm_go) begin
            mm_a_reg   <= (cmd.mm_sel == MS_TERM_X) ? term_reg : inv_reg;
            mm_b_reg   <= (cmd.mm_sel == MS_TERM_X) ? xm_reg : cm_reg;
            mm_acc_reg <= '0;
            mm_cnt_reg <= CNT_W'(VALUE_BITS);
        end else if (mm_busy_reg) begin
            mm_a_reg   <= mm_a_n;
            mm_b_reg   <= mm_b_reg >> 1;
            mm_acc_reg <= mm_acc_n;
            mm_cnt_reg <= mm_cnt_reg - CNT_W'(1);
            if (mm_cnt_reg == CNT_W'(1)) begin
                term_reg <= mm_acc_n;
            end
        end

        if (cmd.div_go) begin
            dsel_reg <= cmd.div_sel;
        end
        if (div_done) begin
            case (dsel_reg)
                DS_C:    c_reg <= div_q;
                DS_EUC:  begin q_reg <= div_q; rdiv_reg <= div_r; end
                DS_SABS: srem_reg <= div_r;
                DS_INV:  inv_reg <= div_r;
                DS_CM:   cm_reg <= div_r;
                DS_XM:   xm_reg <= div_r;
                default: ;
            endcase
        end

        case (cmd.op)
            OP_CLEAR: begin
                for (int k = 0; k < MAX_PARTS; k++) begin
                    resid_reg[k] <= resid_in[k];
                end
                i_reg   <= '0;
                res_reg <= '0;
            end
            OP_EUC_INIT: begin
                r0_reg <= c_reg;
                r1_reg <= p_cur;
                s0_reg <= SW'(1);
                s1_reg <= '0;
            end
            OP_EUC_MUL: prod_reg <= $signed({2'b00, q_reg}) * s1_reg;
            OP_EUC_UPD: begin
                r0_reg <= r1_reg;
                r1_reg <= rdiv_reg;
                s0_reg <= s1_reg;
                s1_reg <= s0_reg - prod_reg;
            end
            // negative Bezout coefficient folds back into [0, p)
            OP_FIX: inv_reg <= (s0_neg && srem_reg != '0) ? p_cur - srem_reg : srem_reg;
            OP_ACC: res_reg <= (rsum >= {1'b0, total}) ? VALUE_BITS'(rsum - {1'b0, total})
                                                       : rsum[VALUE_BITS-1:0];
            OP_NEXT: i_reg <= i_reg + PART_CNT_W'(1);
            default: ;
        endcase
    end

    always_comb begin
        stat.done       = div_done | mm_done_reg;
        stat.part_avail = NUM_PARTS_W'(i_reg) < used;
        stat.part_skip  = (p_cur == '0) || (total == '0);
        stat.r1_zero    = (r1_reg == '0);
    end

    assign value = res_reg;

endmodule
`default_nettype wire

>>> rtl/crt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crt_ctrl
// Sequencer for the CRT datapath: walks the parts, runs Euclid, the
// reductions and the two modular products, then presents the result.
// ----------------------------------------------------------------------------
module crt_ctrl (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  wire logic     m_ready,
    input  crt_pkg::stat_t stat,
    output crt_pkg::cmd_t  cmd
);
    import crt_pkg::*;

    localparam logic [4:0] ST_IDLE     = 5'd0;
    localparam logic [4:0] ST_PART     = 5'd1;
    localparam logic [4:0] ST_EUC_INIT = 5'd2;
    localparam logic [4:0] ST_EUC_TEST = 5'd3;
    localparam logic [4:0] ST_EUC_MUL  = 5'd4;
    localparam logic [4:0] ST_EUC_UPD  = 5'd5;
    localparam logic [4:0] ST_S_RED    = 5'd6;
    localparam logic [4:0] ST_FIX      = 5'd7;
    localparam logic [4:0] ST_INV_RED  = 5'd8;
    localparam logic [4:0] ST_CM_RED   = 5'd9;
    localparam logic [4:0] ST_XM_RED   = 5'd10;
    localparam logic [4:0] ST_MM1      = 5'd11;
    localparam logic [4:0] ST_MM2      = 5'd12;
    localparam logic [4:0] ST_ACC      = 5'd13;
    localparam logic [4:0] ST_NEXT     = 5'd14;
    localparam logic [4:0] ST_DONE     = 5'd15;
    localparam logic [4:0] ST_WAIT     = 5'd16;

    logic [4:0] state_reg, state_next;
    logic [4:0] ret_reg, ret_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        cmd.op      = OP_NOP;
        cmd.div_go  = 1'b0;
        cmd.div_sel = DS_C;
        cmd.mm_go   = 1'b0;
        cmd.mm_sel  = MS_INV_C;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_CLEAR;
                    state_next = ST_PART;
                end
            end
            ST_PART: begin
                if (!stat.part_avail) begin
                    state_next = ST_DONE;
                end else if (stat.part_skip) begin
                    state_next = ST_NEXT;
                end else begin
                    cmd.div_go  = 1'b1;
                    cmd.div_sel = DS_C;
                    ret_next    = ST_EUC_INIT;
                    state_next  = ST_WAIT;
                end
            end
            ST_EUC_INIT: begin
                cmd.op     = OP_EUC_INIT;
                state_next = ST_EUC_TEST;
            end
            ST_EUC_TEST: begin
                if (stat.r1_zero) begin
                    state_next = ST_S_RED;
                end else begin
                    cmd.div_go  = 1'b1;
                    cmd.div_sel = DS_EUC;
                    ret_next    = ST_EUC_MUL;
                    state_next  = ST_WAIT;
                end
            end
            ST_EUC_MUL: begin
                cmd.op     = OP_EUC_MUL;
                state_next = ST_EUC_UPD;
            end
            ST_EUC_UPD: begin
                cmd.op     = OP_EUC_UPD;
                state_next = ST_EUC_TEST;
            end
            ST_S_RED: begin
                cmd.div_go  = 1'b1;
                cmd.div_sel = DS_SABS;
                ret_next    = ST_FIX;
                state_next  = ST_WAIT;
            end
            ST_FIX: begin
                cmd.op     = OP_FIX;
                state_next = ST_INV_RED;
            end
            ST_INV_RED: begin
                cmd.div_go  = 1'b1;
                cmd.div_sel = DS_INV;
                ret_next    = ST_CM_RED;
                state_next  = ST_WAIT;
            end
            ST_CM_RED: begin
                cmd.div_go  = 1'b1;
                cmd.div_sel = DS_CM;
                ret_next    = ST_XM_RED;
                state_next  = ST_WAIT;
            end
            ST_XM_RED: begin
                cmd.div_go  = 1'b1;
                cmd.div_sel = DS_XM;
                ret_next    = ST_MM1;
                state_next  = ST_WAIT;
            end
            ST_MM1: begin
                cmd.mm_go  = 1'b1;
                cmd.mm_sel = MS_INV_C;
                ret_next   = ST_MM2;
                state_next = ST_WAIT;
            end
            ST_MM2: begin
                cmd.mm_go  = 1'b1;
                cmd.mm_sel = MS_TERM_X;
                ret_next   = ST_ACC;
                state_next = ST_WAIT;
            end
            ST_ACC: begin
                cmd.op     = OP_ACC;
                state_next = ST_NEXT;
            end
            ST_NEXT: begin
                cmd.op     = OP_NEXT;
                state_next = ST_PART;
            end
            ST_DONE: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            ST_WAIT: begin
                if (stat.done) begin
                    state_next = ret_reg;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_DONE);

endmodule
`default_nettype wire

>>> test/residue_to_integer_crt_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// residue_to_integer_crt_unit_test
// Self-checking bench for the CRT reconstruction unit. A directed table covers
// reset values, extremes and degenerate moduli, then random residues run over
// many register settings (mostly coprime prime-power sets, some raw noise)
// with and without random idling on both channels. Every result beat is
// compared with the table's value or with a built-in predictor.
// ----------------------------------------------------------------------------
module residue_to_integer_crt_unit_test;
    import crt_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(REG_PART_BASE + MAX_PARTS);
    localparam logic [CFG_IDX_W-1:0] REG_TOP   = '1;
    localparam word_t                ALL_ONES  = '1;
    localparam int                   RANDOM_ITEMS = 1450;
    localparam int                   EXP_DEPTH = 4;

    typedef struct packed {
        int         apply_cfg;
        int         known;
        logic [2:0] np;
        word_t      total;
        word_t      p0, p1, p2, p3;
        word_t      r0, r1, r2, r3;
        word_t      value;
    } dir_row_t;

    typedef struct {
        logic [2:0] np;
        word_t      total;
        word_t      part[MAX_PARTS];
    } crt_cfg_t;

    localparam int NUM_DIR = 18;
    localparam dir_row_t DIRECTED[NUM_DIR] = '{
        // reset values (everything modulo 1), then small moduli
        '{0, 1, 3'd1, 31'd1, 31'd1, 31'd1, 31'd1, 31'd1, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 31'd0},
        '{0, 1, 3'd1, 31'd1, 31'd1, 31'd1, 31'd1, 31'd1, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0},
        '{1, 1, 3'd1, 31'd7, 31'd7, 31'd1, 31'd1, 31'd1, 31'd5, 31'd0, 31'd0, 31'd0, 31'd5},
        '{0, 1, 3'd1, 31'd7, 31'd7, 31'd1, 31'd1, 31'd1, ALL_ONES, 31'd9, 31'd9, 31'd9, 31'd1},
        '{1, 1, 3'd2, 31'd15, 31'd3, 31'd5, 31'd1, 31'd1, 31'd2, 31'd3, 31'd0, 31'd0, 31'd8},
        // residues above their part modulus
        '{0, 0, 3'd2, 31'd15, 31'd3, 31'd5, 31'd1, 31'd1, 31'd10, 31'd20, 31'd0, 31'd0, 31'd0},
        '{0, 1, 3'd2, 31'd15, 31'd3, 31'd5, 31'd1, 31'd1, 31'd0, 31'd0, ALL_ONES, ALL_ONES, 31'd0},
        // no parts in use
        '{1, 1, 3'd0, 31'd15, 31'd3, 31'd5, 31'd1, 31'd1, 31'd1, 31'd1, 31'd1, 31'd1, 31'd0},
        // zero total modulus
        '{1, 1, 3'd2, 31'd0, 31'd3, 31'd5, 31'd1, 31'd1, 31'd1, 31'd1, 31'd1, 31'd1, 31'd0},
        // zero part modulus
        '{1, 1, 3'd1, 31'd5, 31'd0, 31'd5, 31'd1, 31'd1, 31'd3, 31'd1, 31'd1, 31'd1, 31'd0},
        // part count at and above the maximum
        '{1, 0, 3'd7, 31'd210, 31'd2, 31'd3, 31'd5, 31'd7, 31'd1, 31'd2, 31'd3, 31'd4, 31'd0},
        '{1, 0, 3'd4, 31'd210, 31'd2, 31'd3, 31'd5, 31'd7, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 31'd0},
        // moduli not coprime, then the largest single modulus
        '{1, 0, 3'd2, 31'd12, 31'd4, 31'd6, 31'd1, 31'd1, 31'd3, 31'd5, 31'd0, 31'd0, 31'd0},
        '{1, 1, 3'd1, ALL_ONES, ALL_ONES, 31'd1, 31'd1, 31'd1, ALL_ONES, 31'd0, 31'd0, 31'd0, 31'd0},
        '{0, 1, 3'd1, ALL_ONES, ALL_ONES, 31'd1, 31'd1, 31'd1, 31'h7FFF_FFFE, 31'd0, 31'd0, 31'd0,
            31'h7FFF_FFFE},
        // wrong products, then a part count above the maximum with a zero part
        '{1, 0, 3'd3, 31'd31, 31'd2, 31'd3, 31'd5, 31'd1, 31'd1, 31'd2, 31'd4, 31'd0, 31'd0},
        '{1, 0, 3'd4, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 31'h5555_5555,
            31'h2AAA_AAAA, 31'd0, 31'd0},
        '{1, 0, 3'd5, 31'd1001, 31'd7, 31'd11, 31'd13, 31'd0, 31'd6, 31'd10, 31'd12, 31'd3, 31'd0}
    };

    localparam int NUM_PRIMES = 20;
    localparam int PRIMES[NUM_PRIMES] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43,
        47, 53, 59, 61, 46337, 65521};

    logic  aclk = 1'b0;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    word_t s_residue_0 = '0, s_residue_1 = '0, s_residue_2 = '0, s_residue_3 = '0;
    logic  m_valid;
    logic  m_ready = 1'b0;
    word_t m_value;
    logic  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    word_t cfg_data = '0;

    residue_to_integer_crt_unit i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_residue_0 (s_residue_0),
        .s_residue_1 (s_residue_1),
        .s_residue_2 (s_residue_2),
        .s_residue_3 (s_residue_3),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // shadow registers for the predictor
    crt_cfg_t cur_cfg;
    // expected values, written by the sender and read by the result checker
    word_t    exp_values[EXP_DEPTH];
    int       sent_count = 0;
    int       checked_count = 0;
    int       err_count = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    logic     hold_toggle = 1'b0;
    logic     hold_seen = 1'b0;
    int       hold_left = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #1_000_000_000;
        $display("residue_to_integer_crt_unit_test: done, errors");
        $finish;
    end

    function automatic longint unsigned bezout_inverse(longint unsigned c, longint unsigned p);
        longint r0, r1, s0, s1, q, t, rem;
        r0 = longint'(c);
        r1 = longint'(p);
        s0 = 1;
        s1 = 0;
        while (r1 != 0) begin
            q  = r0 / r1;
            t  = r0 - q * r1;
            r0 = r1;
            r1 = t;
            t  = s0 - q * s1;
            s0 = s1;
            s1 = t;
        end
        rem = s0 % longint'(p);
        if (rem < 0) rem += longint'(p);
        return longint'(rem);
    endfunction

    function automatic word_t crt_value(input word_t r[MAX_PARTS]);
        longint unsigned m, acc, p, c, inv, x, term;
        int used;
        m    = cur_cfg.total;
        acc  = 0;
        used = (cur_cfg.np > MAX_PARTS) ? MAX_PARTS : int'(cur_cfg.np);
        if (m != 0) begin
            for (int i = 0; i < used; i++) begin
                p = cur_cfg.part[i];
                if (p == 0) continue;
                c    = m / p;
                inv  = bezout_inverse(c, p) % m;
                x    = r[i] % m;
                term = (inv * (c % m)) % m;
                term = (term * x) % m;
                acc += term;
                if (acc >= m) acc -= m;
            end
        end
        return word_t'(acc);
    endfunction

    // result side: random stall, long hold-off on request, compare
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (sent_count == checked_count) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("unexpected result beat: value=%0d", m_value);
                end else begin
                    if (m_value !== exp_values[checked_count % EXP_DEPTH]) begin
                        err_count++;
                        if (err_count <= 10)
                            $display("value mismatch: expected %0d, got %0d",
                                     exp_values[checked_count % EXP_DEPTH], m_value);
                    end
                    checked_count++;
                end
            end
            if (hold_toggle != hold_seen) begin
                hold_seen <= hold_toggle;
                hold_left <= 2000;
                m_ready   <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic drain();
        s_valid <= 1'b0;
        while (sent_count != checked_count) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input word_t data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
    endtask

    task automatic load_config(input crt_cfg_t cfg);
        drain();
        reg_write(REG_NUM_PARTS, word_t'(cfg.np) | (word_t'($urandom) << NUM_PARTS_W));
        reg_write(REG_TOTAL, cfg.total);
        for (int i = 0; i < MAX_PARTS; i++)
            reg_write(CFG_IDX_W'(REG_PART_BASE + i), cfg.part[i]);
        // indexes past the list must be ignored
        reg_write(REG_SPARE, word_t'($urandom));
        reg_write(REG_TOP, word_t'($urandom));
        cfg_we  <= 1'b0;
        cur_cfg  = cfg;
        @(posedge aclk);
    endtask

    task automatic send_residues(input word_t r[MAX_PARTS], input bit known, input word_t value);
        s_valid     <= 1'b1;
        s_residue_0 <= r[0];
        s_residue_1 <= r[1];
        s_residue_2 <= r[2];
        s_residue_3 <= r[3];
        do @(posedge aclk); while (!s_ready);
        exp_values[sent_count % EXP_DEPTH] = known ? value : crt_value(r);
        sent_count++;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    function automatic crt_cfg_t pick_config();
        crt_cfg_t cfg;
        longint unsigned prod, pp;
        int pi;
        bit used_p[NUM_PRIMES];
        int sel;
        for (int i = 0; i < MAX_PARTS; i++) cfg.part[i] = word_t'($urandom);
        sel = $urandom_range(99);
        if (sel < 18) begin
            // raw noise, sometimes with zeros
            cfg.np    = 3'($urandom_range(0, 7));
            cfg.total = ($urandom_range(3) == 0) ? word_t'($urandom_range(0, 1000))
                                                 : word_t'($urandom);
            for (int i = 0; i < MAX_PARTS; i++)
                if ($urandom_range(7) == 0) cfg.part[i] = '0;
                else if ($urandom_range(1) == 0) cfg.part[i] = word_t'($urandom_range(1, 500));
        end else if (sel < 24) begin
            cfg.np      = 3'd1;
            cfg.total   = ALL_ONES;
            cfg.part[0] = ALL_ONES;
        end else begin
            sel    = $urandom_range(99);
            cfg.np = (sel < 45) ? 3'd1 : (sel < 80) ? 3'd2 : (sel < 93) ? 3'd3 : 3'd4;
            prod   = 1;
            foreach (used_p[k]) used_p[k] = 1'b0;
            for (int i = 0; i < int'(cfg.np); i++) begin
                do pi = $urandom_range(NUM_PRIMES - 1); while (used_p[pi]);
                used_p[pi] = 1'b1;
                pp = PRIMES[pi];
                if (prod * pp >= 64'h8000_0000) pp = 1;
                else
                    while ($urandom_range(1) == 1 && prod * pp * PRIMES[pi] < 64'h8000_0000)
                        pp *= PRIMES[pi];
                cfg.part[i] = word_t'(pp);
                prod *= pp;
            end
            cfg.total = word_t'(prod);
        end
        return cfg;
    endfunction

    function automatic word_t pick_residue(input word_t p);
        int sel;
        sel = $urandom_range(99);
        if (p == 0 || sel < 20) return word_t'($urandom);
        if (sel < 25) return '0;
        if (sel < 30) return p - 1;
        if (sel < 33) return ALL_ONES;
        return word_t'({$urandom, $urandom} % p);
    endfunction

    initial begin
        word_t    r[MAX_PARTS];
        crt_cfg_t cfg;
        int       items_sent;
        int       phase_len;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        cur_cfg.np    = 3'd1;
        cur_cfg.total = 31'd1;
        for (int i = 0; i < MAX_PARTS; i++) cur_cfg.part[i] = 31'd1;

        foreach (DIRECTED[n]) begin
            if (DIRECTED[n].apply_cfg != 0) begin
                cfg.np      = DIRECTED[n].np;
                cfg.total   = DIRECTED[n].total;
                cfg.part[0] = DIRECTED[n].p0;
                cfg.part[1] = DIRECTED[n].p1;
                cfg.part[2] = DIRECTED[n].p2;
                cfg.part[3] = DIRECTED[n].p3;
                load_config(cfg);
            end
            r[0] = DIRECTED[n].r0;
            r[1] = DIRECTED[n].r1;
            r[2] = DIRECTED[n].r2;
            r[3] = DIRECTED[n].r3;
            send_residues(r, DIRECTED[n].known != 0, DIRECTED[n].value);
        end

        items_sent = 0;
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 17 : (mode == 1) ? 74 : 0;
            recv_idle_pct = (mode == 0) ? 74 : (mode == 1) ? 17 : 0;
            while (items_sent < (RANDOM_ITEMS * (mode + 1)) / 3) begin
                cfg = pick_config();
                load_config(cfg);
                // long receiver hold-off while the sender keeps offering beats
                if (mode == 0 && items_sent == 0) hold_toggle = ~hold_toggle;
                phase_len = (cfg.total == cfg.part[0] || cfg.np == 3'd1) ? 40 :
                            (cfg.np > 3'd2) ? 12 : 30;
                for (int k = 0; k < phase_len; k++) begin
                    for (int i = 0; i < MAX_PARTS; i++) r[i] = pick_residue(cfg.part[i]);
                    send_residues(r, 1'b0, '0);
                    items_sent++;
                end
            end
        end

        s_valid <= 1'b0;
        while (sent_count != checked_count) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (err_count == 0 && sent_count == checked_count)
            $display("residue_to_integer_crt_unit_test: done, clean");
        else
            $display("residue_to_integer_crt_unit_test: done, errors");
        $finish;
    end

endmodule

>>> sim.f
rtl/crt_pkg.sv
rtl/crt_div.sv
rtl/crt_dp.sv
rtl/crt_ctrl.sv
rtl/residue_to_integer_crt_unit.sv
test/residue_to_integer_crt_unit_test.sv
